/* rtl/dcmtf_pkg.sv */
package dcmtf_pkg;

  localparam int COLOR_W = 6;
  localparam int RANK_W  = 17;

  localparam int NUM_COLORS_DEF = 64;
  localparam int DECK_MAX_DEF   = 65536;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] color;
  } item_t;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              found;
  } result_t;

endpackage

/* rtl/deck_color_move_to_front.sv */
// Move-to-front deck ranker.
//
// Input channel (item_valid / item_ready / item): each transaction is either
// a load (kind = KIND_LOAD), which appends a card of the given color at the
// deck bottom, or a query (kind = KIND_QUERY), which names a color.
// Output channel (result_valid / result_ready / result): one transaction per
// query, none per load. rank is the 1-based position of the topmost card of
// the color, found says whether one exists; an absent color gives 0 / 0.
// A found card moves to the top: every color above it moves down by one.
//
// Sequencing: a query looks up its color's entry; on a hit it sweeps the
// whole store and then moves the color to the top, while an absent color
// skips the sweep. The sweep walks the per-color position store one entry
// per cycle through a single compare and increment unit, with one read and
// one write port on the store. item_ready is high only while the sequencer
// is idle, so loads go at one per cycle and a query must finish before the
// next transaction is accepted.
// The result sits in an output register; a stalled receiver does not block
// loads or the next query, but a finished query waits until the register
// frees up. Reset clears the deck count and all store valid bits at once,
// so the block is ready in the first cycle after reset.
module deck_color_move_to_front
  import dcmtf_pkg::*;
#(
  parameter int NUM_COLORS = NUM_COLORS_DEF,
  parameter int DECK_MAX   = DECK_MAX_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int CW    = $clog2(NUM_COLORS);
  localparam int POS_W = $clog2(DECK_MAX + 1);
  localparam logic [CW-1:0]    LAST_IDX  = CW'(NUM_COLORS - 1);
  localparam logic [POS_W-1:0] DECK_FULL = POS_W'(DECK_MAX);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOOKUP = 5'b00010,
    ST_SWEEP  = 5'b00100,
    ST_FIX    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t           st;
  logic [CW-1:0]    cnt;
  logic [CW-1:0]    qcolor;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] cards_loaded;
  logic [POS_W-1:0] res_rank;
  logic             res_found;

  logic             rd_en;
  logic [CW-1:0]    rd_addr;
  logic [POS_W-1:0] rd_data;
  logic             rd_hit;
  logic             wr_en;
  logic [CW-1:0]    wr_addr;
  logic [POS_W-1:0] wr_data;
  logic             probe_hit;

  logic                  accept;
  logic                  out_free;
  logic                  color_ok;
  logic                  deck_full;
  logic [CW+COLOR_W-1:0] color_ext;
  logic [CW-1:0]         color_addr;
  logic [RANK_W+POS_W-1:0] rank_ext;

  assign item_ready = (st == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign out_free   = !result_valid || result_ready;
  assign color_ok   = (32'(item.color) < NUM_COLORS);
  assign deck_full  = (cards_loaded >= DECK_FULL);
  assign color_ext  = {{CW{1'b0}}, item.color};
  assign color_addr = color_ext[CW-1:0];
  // Mask the stored position to the rank field width.
  assign rank_ext   = {{RANK_W{1'b0}}, res_rank};

  dcmtf_store #(
    .NUM_COLORS (NUM_COLORS),
    .POS_W      (POS_W)
  ) u_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .rd_hit     (rd_hit),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .probe_addr (color_addr),
    .probe_hit  (probe_hit)
  );

  // Store port control. The sweep reads entry cnt+1 while it writes back
  // entry cnt, so the two ports never touch the same entry.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt + CW'(1);
    wr_en   = 1'b0;
    wr_addr = cnt;
    wr_data = rd_data + POS_W'(1);
    case (st)
      ST_IDLE: begin
        rd_addr = color_addr;
        if (accept && color_ok) begin
          if (item.kind == KIND_QUERY) begin
            rd_en = 1'b1;
          end else if (!deck_full && !probe_hit) begin
            // First card of this color: record its position.
            wr_en   = 1'b1;
            wr_addr = color_addr;
            wr_data = cards_loaded + POS_W'(1);
          end
        end
      end
      ST_LOOKUP: begin
        rd_en   = rd_hit;
        rd_addr = '0;
      end
      ST_SWEEP: begin
        // Push down every present color that sits above the found card.
        rd_en = (cnt != LAST_IDX);
        wr_en = rd_hit && (rd_data < pos);
      end
      ST_FIX: begin
        wr_en   = 1'b1;
        wr_addr = qcolor;
        wr_data = POS_W'(1);
      end
      default: begin
      end
    endcase
  end

  // Sequencer control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= ST_IDLE;
      cnt          <= '0;
      cards_loaded <= '0;
      result_valid <= 1'b0;
    end else begin
      case (st)
        ST_IDLE: begin
          if (accept) begin
            if (item.kind == KIND_LOAD) begin
              if (color_ok && !deck_full) begin
                cards_loaded <= cards_loaded + POS_W'(1);
              end
            end else if (color_ok) begin
              st <= ST_LOOKUP;
            end else begin
              st <= ST_DONE;
            end
          end
        end
        ST_LOOKUP: begin
          cnt <= '0;
          st  <= rd_hit ? ST_SWEEP : ST_DONE;
        end
        ST_SWEEP: begin
          cnt <= cnt + CW'(1);
          if (cnt == LAST_IDX) begin
            st <= ST_FIX;
          end
        end
        ST_FIX: begin
          st <= ST_DONE;
        end
        ST_DONE: begin
          // Hold the result until the output register frees up.
          if (out_free) begin
            st <= ST_IDLE;
          end
        end
        default: begin
          st <= ST_IDLE;
        end
      endcase

      if (st == ST_DONE && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        qcolor    <= color_addr;
        res_rank  <= '0;
        res_found <= 1'b0;
      end
      ST_LOOKUP: begin
        pos <= rd_data;
      end
      ST_FIX: begin
        res_rank  <= pos;
        res_found <= 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          result.rank  <= rank_ext[RANK_W-1:0];
          result.found <= res_found;
        end
      end
      default: begin
      end
    endcase
  end

  // Sweep write-back never collides with the look-ahead read.
  a_sweep_ports: assert property (@(posedge clk) disable iff (rst)
    (st == ST_SWEEP && wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("sweep read and write hit the same entry");

  // A miss always reports rank zero.
  a_miss_rank: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !result.found) |-> (result.rank == '0))
    else $error("absent color returned a nonzero rank");

  // The deck count never passes capacity.
  a_deck_cap: assert property (@(posedge clk) disable iff (rst)
    (cards_loaded <= DECK_FULL))
    else $error("card count exceeds deck capacity");

  // Leaving the done state always presents a result.
  a_done_out: assert property (@(posedge clk) disable iff (rst)
    (st == ST_DONE && out_free) |=> (result_valid && st == ST_IDLE))
    else $error("finished query did not reach the output register");

endmodule

/* rtl/dcmtf_store.sv */
module dcmtf_store
  import dcmtf_pkg::*;
#(
  parameter int NUM_COLORS = NUM_COLORS_DEF,
  parameter int POS_W      = 17,
  localparam int CW        = $clog2(NUM_COLORS)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             rd_en,
  input  logic [CW-1:0]    rd_addr,
  output logic [POS_W-1:0] rd_data,
  output logic             rd_hit,
  input  logic             wr_en,
  input  logic [CW-1:0]    wr_addr,
  input  logic [POS_W-1:0] wr_data,
  input  logic [CW-1:0]    probe_addr,
  output logic             probe_hit
);

  // Top position per color; an entry without its valid bit reads as absent.
  logic [POS_W-1:0]      mem [NUM_COLORS];
  logic [NUM_COLORS-1:0] valid;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
      rd_hit  <= valid[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign probe_hit = valid[probe_addr];

endmodule

/* dv/deck_color_move_to_front_tb.sv */
`timescale 1ns / 100ps

// Testbench for the move-to-front deck ranker.
//
// Load and query transactions drive the block from a task. A monitor on the
// item channel runs each accepted transaction through a local model of the
// deck. That model keeps the top slot of each color and the card count. Each
// query pushes the rank it should return. A second monitor on the result
// channel checks every returned transaction against the oldest pending
// rank.
//
// The run goes through these tests in order:
//   - a directed pass over the corner cases,
//   - four random phases with different sender idling and receiver stalls.
module deck_color_move_to_front_tb;
  import dcmtf_pkg::*;

  localparam int NCOLORS         = NUM_COLORS_DEF;
  localparam int DECK_CAP        = DECK_MAX_DEF;
  localparam int ITEMS_PER_PHASE = 350;
  // A query sweeps every color once, so this covers the longest sweep.
  localparam int SETTLE_CYCLES   = NCOLORS + 16;

  // No load ever uses this color, so a query of it must stay absent.
  localparam logic [COLOR_W-1:0] NEVER_C = 6'd40;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    item_valid   = 1'b0;
  logic    item_ready;
  item_t   item         = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  deck_color_move_to_front dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  always #1 clk = ~clk;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;

  // Deck model: the top slot of each color (zero means absent) and the card
  // count.
  logic [RANK_W-1:0] top_slot [NCOLORS];
  logic [RANK_W-1:0] deck_size;
  // Ranks owed by the block, oldest first.
  result_t           pending_ranks [$];
  // Colors handed to a load so far; the generator uses this to aim queries.
  bit                gen_loaded [NCOLORS];
  logic [COLOR_W-1:0] last_query = '0;

  // Apply one accepted transaction to the deck model; queue the rank a query
  // should return.
  function automatic void mtf_apply(item_t it);
    logic [RANK_W-1:0] p;
    result_t           r;
    if (it.kind == KIND_LOAD) begin
      // Drop loads past capacity. A repeated color keeps its top slot.
      if (int'(it.color) < NCOLORS && int'(deck_size) < DECK_CAP) begin
        deck_size++;
        if (top_slot[it.color] == '0) begin
          top_slot[it.color] = deck_size;
        end
      end
      return;
    end
    r = '0;
    if (int'(it.color) < NCOLORS && top_slot[it.color] != '0) begin
      p = top_slot[it.color];
      // Shift down every color above the found card; leave the ones below.
      for (int k = 0; k < NCOLORS; k++) begin
        if (top_slot[k] != '0 && top_slot[k] < p) begin
          top_slot[k]++;
        end
      end
      top_slot[it.color] = RANK_W'(1);
      r.rank  = p;
      r.found = 1'b1;
    end
    pending_ranks.push_back(r);
  endfunction

  // Item channel monitor: sample at the edge, before the block's updates.
  always @(posedge clk) begin
    if (!rst && item_valid && item_ready) begin
      mtf_apply(item);
    end
  end

  // Result channel checker: compare each returned transaction with the oldest
  // pending rank.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && result_ready) begin
      if (pending_ranks.size() == 0) begin
        $error("result with no query outstanding: rank %0d found %0b",
               result.rank, result.found);
        error_count++;
      end else begin
        want = pending_ranks.pop_front();
        if (result.rank !== want.rank) begin
          $error("rank: expected %0d, actual %0d", want.rank, result.rank);
          error_count++;
        end
        if (result.found !== want.found) begin
          $error("found: expected %0b, actual %0b", want.found, result.found);
          error_count++;
        end
      end
    end
  end

  // Receiver: stall at random according to the current phase.
  always @(posedge clk) begin
    result_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one transaction. Hold valid across back-to-back transactions; drop
  // it only while idling.
  task automatic send_card(input logic kind, input logic [COLOR_W-1:0] color);
    item_t it;
    it.kind  = kind;
    it.color = color;
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    if (kind == KIND_LOAD) begin
      gen_loaded[color] = 1'b1;
    end else begin
      last_query = color;
    end
    item_valid <= 1'b1;
    item       <= it;
    do @(posedge clk); while (!item_ready);
  endtask

  // Hold the sender until every pending rank has come back.
  task automatic wait_results();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_ranks.size() != 0) @(posedge clk);
  endtask

  function automatic logic [COLOR_W-1:0] pick_load_color();
    logic [COLOR_W-1:0] c;
    do c = COLOR_W'($urandom_range(NCOLORS - 1));
    while (c == NEVER_C);
    return c;
  endfunction

  // Aim most queries at loaded colors. Repeat the previous query now and
  // then, which hits the top slot if that query found its color. Leave the
  // rest fully random, which includes absent colors.
  function automatic logic [COLOR_W-1:0] pick_query_color();
    logic [COLOR_W-1:0] c;
    if ($urandom_range(99) < 10) begin
      return last_query;
    end
    c = COLOR_W'($urandom_range(NCOLORS - 1));
    if ($urandom_range(99) < 25) begin
      return c;
    end
    repeat (NCOLORS) begin
      if (gen_loaded[c]) begin
        return c;
      end
      c = COLOR_W'($urandom_range(NCOLORS - 1));
    end
    return c;
  endfunction

  // Corner cases: queries on an empty deck, repeated loads of one color,
  // extreme colors, a query of the card already on top, and absent colors.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_card(KIND_QUERY, 6'd0);
    send_card(KIND_QUERY, 6'd63);
    send_card(KIND_LOAD, 6'd5);
    send_card(KIND_LOAD, 6'd0);
    send_card(KIND_LOAD, 6'd5);
    send_card(KIND_LOAD, 6'd63);
    send_card(KIND_LOAD, 6'd0);
    send_card(KIND_QUERY, 6'd63);
    send_card(KIND_QUERY, 6'd63);
    send_card(KIND_QUERY, 6'd0);
    send_card(KIND_QUERY, 6'd17);
    send_card(KIND_LOAD, 6'd17);
    send_card(KIND_QUERY, 6'd5);
    send_card(KIND_QUERY, 6'd17);
    send_card(KIND_QUERY, NEVER_C);
    send_card(KIND_QUERY, 6'd63);
    wait_results();
  endtask

  // Mix loads and queries at random under one sender idling and receiver stall pattern.
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input int n);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (n) begin
      if ($urandom_range(99) < 35) begin
        send_card(KIND_LOAD, pick_load_color());
      end else begin
        send_card(KIND_QUERY, pick_query_color());
      end
    end
    wait_results();
  endtask

  initial begin
    foreach (top_slot[i]) top_slot[i] = '0;
    deck_size = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_phase(0, 0, ITEMS_PER_PHASE);
    test_random_phase(85, 0, ITEMS_PER_PHASE);
    test_random_phase(0, 85, ITEMS_PER_PHASE);
    test_random_phase(27, 27, ITEMS_PER_PHASE);

    // Let any stray result show up before closing out.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_ranks.size() == 0) begin
      $display("deck_color_move_to_front_tb: done, clean");
    end else begin
      $display("deck_color_move_to_front_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("deck_color_move_to_front_tb: done, errors");
    $finish;
  end

endmodule

/* deck_color_move_to_front.f */
rtl/dcmtf_pkg.sv
rtl/dcmtf_store.sv
rtl/deck_color_move_to_front.sv
dv/deck_color_move_to_front_tb.sv
